>>> rtl/msc_pkg.sv
`timescale 1ns / 1ps

package msc_pkg;

    // Fixed field widths of the item, result and register formats.
    localparam int GREY_W      = 16;
    localparam int GAIN_W      = 24;
    localparam int GAIN_FRAC   = 16;
    localparam int VAR_W       = 2 * GREY_W;
    localparam int ROOT_W      = GREY_W;
    localparam int DIGIT_W     = 4;
    localparam int OUT_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int OP_W        = 2;
    localparam int CFG_INDEX_W = 2;

    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
    localparam logic [OP_W-1:0] OP_GATHER   = 2'd1;
    localparam logic [OP_W-1:0] OP_FINALIZE = 2'd2;
    localparam logic [OP_W-1:0] OP_MAP      = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FLAT = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_MEAN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_SPREAD = 2'd1;

    localparam logic [GREY_W-1:0] TARGET_MEAN_RESET   = 16'd32640;
    localparam logic [GREY_W-1:0] TARGET_SPREAD_RESET = 16'd6528;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_MAP_MUL,
        ST_DIV_MEAN,
        ST_MUL_NS2,
        ST_MUL_SS,
        ST_DIV_VAR,
        ST_SQRT,
        ST_DIV_GAIN,
        ST_REPLY
    } state_t;

endpackage

>>> rtl/mean_spread_contrast_stretch.sv
`timescale 1ns / 1ps

// Contrast stretch to a target mean and standard deviation, on unsigned grey values with
// FRACTION_BITS fraction bits. Items arrive on the item channel with an opcode: clear zeroes
// the statistics, gather adds a value above 1.0 to the sum, the sum of squares and the count,
// finalize derives mean, sample deviation and gain and answers with a status, and map answers
// with target_mean + gain * (value - mean) saturated to 0..255. One item is worked on at a
// time and the item channel stalls while it is. Clear and an ignored gather are done in the
// idle state; a counted gather and a map run through a shared 4-bit digit-serial multiplier
// that forms the square or the gain product. Finalize runs through the bit-serial chain:
// mean division, the products n * sum_sq and sum * sum, the variance division, the square
// root and the gain division, each one bit per cycle. A finalize over fewer than two values
// goes straight to its reply, and one that finds a zero deviation skips the gain division.
// A finished result sits in an output register, so the next item is taken while it waits
// for its transfer. The configuration port is ready whenever the item channel is not stalled.

module mean_spread_contrast_stretch
    import msc_pkg::*;
#(
    parameter int MAX_PIXELS    = 16777216,
    parameter int FRACTION_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic [OP_W-1:0]        opcode,
    input  logic [GREY_W-1:0]      grey_value,

    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [OUT_W-1:0]       mapped_grey,
    output logic [STATUS_W-1:0]    status,
    output logic                   is_finalize_reply,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [GREY_W-1:0]      cfg_data
);

    // Accumulator widths follow from the pixel count; the sum of squares times the count
    // holds the numerator of the variance.
    localparam int CNT_W     = $clog2(MAX_PIXELS + 1);
    localparam int LOG_PIX   = $clog2(MAX_PIXELS);
    localparam int SUM_W     = GREY_W + LOG_PIX;
    localparam int SQ_W      = 2 * GREY_W + LOG_PIX;
    localparam int PROD_W    = CNT_W + SQ_W;
    localparam int MM_W      = 2 * CNT_W;
    localparam int DIV_W     = (MM_W > ROOT_W) ? MM_W : ROOT_W;
    localparam int DS_ACC_W  = GAIN_W + GREY_W;
    localparam int T_W       = DS_ACC_W + 2;
    localparam int MAP_SHIFT = GAIN_FRAC + FRACTION_BITS;
    localparam int DIGITS    = GREY_W / DIGIT_W;
    localparam int SQR_REM_W = ROOT_W + 1;
    localparam int MAX_STEPS = (SUM_W > VAR_W) ? SUM_W : VAR_W;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    localparam logic [GREY_W-1:0] GREY_ONE = GREY_W'(1 << FRACTION_BITS);

    // Control and architectural state.
    state_t                 state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [GREY_W-1:0]      mean_reg, mean_next;
    logic [GAIN_W-1:0]      gain_reg, gain_next;
    logic [STATUS_W-1:0]    fstat_reg, fstat_next;
    logic [GREY_W-1:0]      tmean_reg, tmean_next;
    logic [GREY_W-1:0]      tspread_reg, tspread_next;
    logic                   res_valid_reg, res_valid_next;

    // Serial datapath registers.
    logic [DS_ACC_W-1:0]    ds_acc_reg, ds_acc_next;
    logic [GAIN_W-1:0]      ds_mcand_reg, ds_mcand_next;
    logic [GREY_W-1:0]      ds_mplier_reg, ds_mplier_next;
    logic                   map_neg_reg, map_neg_next;
    logic                   reply_fin_reg, reply_fin_next;
    logic [DIV_W-1:0]       div_rem_reg, div_rem_next;
    logic [VAR_W-1:0]       div_dq_reg, div_dq_next;
    logic [DIV_W-1:0]       div_den_reg, div_den_next;
    logic [PROD_W-1:0]      mul_acc_reg, mul_acc_next;
    logic [PROD_W-1:0]      mul_mcand_reg, mul_mcand_next;
    logic [SUM_W-1:0]       mul_mplier_reg, mul_mplier_next;
    logic [MM_W-1:0]        mm_acc_reg, mm_acc_next;
    logic [MM_W-1:0]        mm_mcand_reg, mm_mcand_next;
    logic [SQR_REM_W-1:0]   sqr_rem_reg, sqr_rem_next;
    logic [ROOT_W-1:0]      sqr_root_reg, sqr_root_next;
    logic [OUT_W-1:0]       grey_out_reg;
    logic [STATUS_W-1:0]    status_out_reg;
    logic                   fin_out_reg;

    // Handshake and decode.
    logic                   busy;
    logic                   reply_load;
    logic                   item_accept;
    logic                   out_free;
    logic                   step_last;
    logic                   gather_ok;
    logic                   fin_few;

    // Digit-serial multiplier: one 4-bit digit of the multiplier per cycle, MSB first.
    logic [DIGIT_W-1:0]         ds_digit;
    logic [GAIN_W+DIGIT_W-1:0]  ds_part;
    logic [DS_ACC_W-1:0]        ds_acc_step;

    // Bit-serial multiplier and restoring divider.
    logic [PROD_W-1:0]      mul_acc_add;
    logic [PROD_W-1:0]      mul_acc_sub;
    logic [MM_W-1:0]        mm_acc_add;
    logic [DIV_W:0]         div_sh;
    logic [DIV_W:0]         div_diff;
    logic                   div_ge;
    logic [DIV_W-1:0]       div_rem_step;
    logic [VAR_W-1:0]       div_dq_step;
    logic [GAIN_W-1:0]      gain_sat;

    // Restoring square root, two radicand bits per cycle.
    logic [SQR_REM_W+1:0]   sqr_sh;
    logic [SQR_REM_W+1:0]   sqr_trial;
    logic [SQR_REM_W+1:0]   sqr_diff;
    logic                   sqr_ge;
    logic [SQR_REM_W-1:0]   sqr_rem_step;
    logic [ROOT_W-1:0]      sqr_root_step;

    // Map output stage.
    logic [T_W-1:0]         map_base;
    logic [T_W-1:0]         map_t;
    logic [T_W-1:0]         map_shifted;
    logic [OUT_W-1:0]       map_grey;

    assign out_free    = !res_valid_reg || !result_stall;
    assign item_accept = item_valid && !busy;
    assign step_last   = (step_reg == STEP_W'(1));
    assign gather_ok   = (grey_value > GREY_ONE) && (cnt_reg < CNT_W'(MAX_PIXELS));
    assign fin_few     = (cnt_reg < CNT_W'(2));

    assign ds_digit    = ds_mplier_reg[GREY_W-1 -: DIGIT_W];
    assign ds_part     = ds_mcand_reg * ds_digit;
    assign ds_acc_step = (ds_acc_reg << DIGIT_W) + DS_ACC_W'(ds_part);

    assign mul_acc_add = mul_acc_reg + mul_mcand_reg;
    assign mul_acc_sub = mul_acc_reg - mul_mcand_reg;
    assign mm_acc_add  = mm_acc_reg + mm_mcand_reg;

    assign div_sh       = {div_rem_reg, div_dq_reg[VAR_W-1]};
    assign div_diff     = div_sh - {1'b0, div_den_reg};
    assign div_ge       = (div_sh >= {1'b0, div_den_reg});
    assign div_rem_step = div_ge ? div_diff[DIV_W-1:0] : div_sh[DIV_W-1:0];
    assign div_dq_step  = {div_dq_reg[VAR_W-2:0], div_ge};
    assign gain_sat     = (|div_dq_step[VAR_W-1:GAIN_W]) ? {GAIN_W{1'b1}}
                                                         : div_dq_step[GAIN_W-1:0];

    // The radicand is the variance quotient, still held in the divider's quotient register.
    assign sqr_sh        = {sqr_rem_reg, div_dq_reg[VAR_W-1 -: 2]};
    assign sqr_trial     = {1'b0, sqr_root_reg, 2'b01};
    assign sqr_diff      = sqr_sh - sqr_trial;
    assign sqr_ge        = (sqr_sh >= sqr_trial);
    assign sqr_rem_step  = sqr_ge ? sqr_diff[SQR_REM_W-1:0] : sqr_sh[SQR_REM_W-1:0];
    assign sqr_root_step = {sqr_root_reg[ROOT_W-2:0], sqr_ge};

    // A negative sum clamps to zero, anything above the top grey level clamps to 255.
    assign map_base    = T_W'({tmean_reg, {GAIN_FRAC{1'b0}}});
    assign map_t       = map_neg_reg ? (map_base - T_W'(ds_acc_reg))
                                     : (map_base + T_W'(ds_acc_reg));
    assign map_shifted = map_t >> MAP_SHIFT;
    assign map_grey    = map_t[T_W-1] ? OUT_W'(0)
                       : (|map_shifted[T_W-1:OUT_W]) ? {OUT_W{1'b1}}
                       : map_shifted[OUT_W-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    unique case (opcode)
                        OP_CLEAR:    state_next = ST_IDLE;
                        OP_GATHER:   state_next = gather_ok ? ST_SQUARE : ST_IDLE;
                        OP_FINALIZE: state_next = fin_few ? ST_REPLY : ST_DIV_MEAN;
                        OP_MAP:      state_next = ST_MAP_MUL;
                    endcase
                end
            end
            ST_SQUARE:   if (step_last) state_next = ST_ACCUM;
            ST_ACCUM:    state_next = ST_IDLE;
            ST_MAP_MUL:  if (step_last) state_next = ST_REPLY;
            ST_DIV_MEAN: if (step_last) state_next = ST_MUL_NS2;
            ST_MUL_NS2:  if (step_last) state_next = ST_MUL_SS;
            ST_MUL_SS:   if (step_last) state_next = ST_DIV_VAR;
            ST_DIV_VAR:  if (step_last) state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (step_last)
                begin
                    state_next = (sqr_root_step == ROOT_W'(0)) ? ST_REPLY : ST_DIV_GAIN;
                end
            end
            ST_DIV_GAIN: if (step_last) state_next = ST_REPLY;
            ST_REPLY:    if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        busy       = 1'b1;
        reply_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:  busy = 1'b0;
            ST_REPLY: reply_load = out_free;
            default:  ;
        endcase
    end

    assign item_stall = busy;
    assign cfg_ready  = !busy;

    // Datapath next values.
    always_comb
    begin
        step_next       = step_reg;
        sum_next        = sum_reg;
        sq_next         = sq_reg;
        cnt_next        = cnt_reg;
        mean_next       = mean_reg;
        gain_next       = gain_reg;
        fstat_next      = fstat_reg;
        tmean_next      = tmean_reg;
        tspread_next    = tspread_reg;
        ds_acc_next     = ds_acc_reg;
        ds_mcand_next   = ds_mcand_reg;
        ds_mplier_next  = ds_mplier_reg;
        map_neg_next    = map_neg_reg;
        reply_fin_next  = reply_fin_reg;
        div_rem_next    = div_rem_reg;
        div_dq_next     = div_dq_reg;
        div_den_next    = div_den_reg;
        mul_acc_next    = mul_acc_reg;
        mul_mcand_next  = mul_mcand_reg;
        mul_mplier_next = mul_mplier_reg;
        mm_acc_next     = mm_acc_reg;
        mm_mcand_next   = mm_mcand_reg;
        sqr_rem_next    = sqr_rem_reg;
        sqr_root_next   = sqr_root_reg;

        // A result waiting in the output register stays until its transfer completes.
        if (reply_load)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && result_stall;
        end

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TARGET_MEAN:   tmean_next = cfg_data;
                REG_TARGET_SPREAD: tspread_next = cfg_data;
                default:           ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    unique case (opcode)
                        OP_CLEAR:
                        begin
                            sum_next = '0;
                            sq_next  = '0;
                            cnt_next = '0;
                        end
                        OP_GATHER:
                        begin
                            if (gather_ok)
                            begin
                                ds_acc_next    = '0;
                                ds_mcand_next  = GAIN_W'(grey_value);
                                ds_mplier_next = grey_value;
                                step_next      = STEP_W'(DIGITS);
                            end
                        end
                        OP_FINALIZE:
                        begin
                            reply_fin_next = 1'b1;
                            if (fin_few)
                            begin
                                mean_next  = (cnt_reg == CNT_W'(1)) ? sum_reg[GREY_W-1:0]
                                                                    : GREY_W'(0);
                                gain_next  = '0;
                                fstat_next = STAT_FEW;
                            end
                            else
                            begin
                                // The mean is below 2^GREY_W, so the top part of the sum
                                // is already smaller than the count.
                                div_rem_next = DIV_W'(sum_reg >> GREY_W);
                                div_dq_next  = {sum_reg[GREY_W-1:0], {GREY_W{1'b0}}};
                                div_den_next = DIV_W'(cnt_reg);
                                step_next    = STEP_W'(GREY_W);
                            end
                        end
                        OP_MAP:
                        begin
                            reply_fin_next = 1'b0;
                            map_neg_next   = (grey_value < mean_reg);
                            ds_mplier_next = (grey_value < mean_reg) ? (mean_reg - grey_value)
                                                                     : (grey_value - mean_reg);
                            ds_mcand_next  = gain_reg;
                            ds_acc_next    = '0;
                            step_next      = STEP_W'(DIGITS);
                        end
                    endcase
                end
            end

            ST_SQUARE, ST_MAP_MUL:
            begin
                ds_acc_next    = ds_acc_step;
                ds_mplier_next = ds_mplier_reg << DIGIT_W;
                step_next      = step_reg - STEP_W'(1);
            end

            ST_ACCUM:
            begin
                sum_next = sum_reg + SUM_W'(ds_mcand_reg[GREY_W-1:0]);
                sq_next  = sq_reg + SQ_W'(ds_acc_reg);
                cnt_next = cnt_reg + CNT_W'(1);
            end

            ST_DIV_MEAN:
            begin
                div_rem_next = div_rem_step;
                div_dq_next  = div_dq_step;
                step_next    = step_reg - STEP_W'(1);
                if (step_last)
                begin
                    mean_next       = div_dq_step[GREY_W-1:0];
                    mul_acc_next    = '0;
                    mul_mcand_next  = PROD_W'(sq_reg);
                    mul_mplier_next = SUM_W'(cnt_reg);
                    mm_acc_next     = '0;
                    mm_mcand_next   = MM_W'(cnt_reg - CNT_W'(1));
                    step_next       = STEP_W'(CNT_W);
                end
            end

            // n * sum_sq and n * (n - 1) share the count's bits as multiplier.
            ST_MUL_NS2:
            begin
                if (mul_mplier_reg[0])
                begin
                    mul_acc_next = mul_acc_add;
                    mm_acc_next  = mm_acc_add;
                end
                mul_mcand_next  = mul_mcand_reg << 1;
                mm_mcand_next   = mm_mcand_reg << 1;
                mul_mplier_next = mul_mplier_reg >> 1;
                step_next       = step_reg - STEP_W'(1);
                if (step_last)
                begin
                    mul_mcand_next  = PROD_W'(sum_reg);
                    mul_mplier_next = sum_reg;
                    step_next       = STEP_W'(SUM_W);
                end
            end

            // Subtract sum * sum; the difference n * sum_sq - sum^2 is never negative.
            ST_MUL_SS:
            begin
                if (mul_mplier_reg[0])
                begin
                    mul_acc_next = mul_acc_sub;
                end
                mul_mcand_next  = mul_mcand_reg << 1;
                mul_mplier_next = mul_mplier_reg >> 1;
                step_next       = step_reg - STEP_W'(1);
                if (step_last)
                begin
                    // The variance fits in VAR_W bits, so the upper part is below n * (n - 1).
                    div_rem_next = DIV_W'((mul_mplier_reg[0] ? mul_acc_sub : mul_acc_reg)
                                          >> VAR_W);
                    div_dq_next  = mul_mplier_reg[0] ? mul_acc_sub[VAR_W-1:0]
                                                     : mul_acc_reg[VAR_W-1:0];
                    div_den_next = DIV_W'(mm_acc_reg);
                    step_next    = STEP_W'(VAR_W);
                end
            end

            ST_DIV_VAR:
            begin
                div_rem_next = div_rem_step;
                div_dq_next  = div_dq_step;
                step_next    = step_reg - STEP_W'(1);
                if (step_last)
                begin
                    sqr_rem_next  = '0;
                    sqr_root_next = '0;
                    step_next     = STEP_W'(ROOT_W);
                end
            end

            ST_SQRT:
            begin
                sqr_rem_next  = sqr_rem_step;
                sqr_root_next = sqr_root_step;
                div_dq_next   = div_dq_reg << 2;
                step_next     = step_reg - STEP_W'(1);
                if (step_last)
                begin
                    if (sqr_root_step == ROOT_W'(0))
                    begin
                        gain_next  = '0;
                        fstat_next = STAT_FLAT;
                    end
                    else
                    begin
                        div_rem_next = '0;
                        div_dq_next  = VAR_W'({tspread_reg, {GAIN_FRAC{1'b0}}});
                        div_den_next = DIV_W'(sqr_root_step);
                        step_next    = STEP_W'(VAR_W);
                    end
                end
            end

            ST_DIV_GAIN:
            begin
                div_rem_next = div_rem_step;
                div_dq_next  = div_dq_step;
                step_next    = step_reg - STEP_W'(1);
                if (step_last)
                begin
                    gain_next  = gain_sat;
                    fstat_next = STAT_OK;
                end
            end

            ST_REPLY: ;

            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            cnt_reg       <= '0;
            mean_reg      <= '0;
            gain_reg      <= '0;
            fstat_reg     <= STAT_OK;
            tmean_reg     <= TARGET_MEAN_RESET;
            tspread_reg   <= TARGET_SPREAD_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            cnt_reg       <= cnt_next;
            mean_reg      <= mean_next;
            gain_reg      <= gain_next;
            fstat_reg     <= fstat_next;
            tmean_reg     <= tmean_next;
            tspread_reg   <= tspread_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ds_acc_reg     <= ds_acc_next;
        ds_mcand_reg   <= ds_mcand_next;
        ds_mplier_reg  <= ds_mplier_next;
        map_neg_reg    <= map_neg_next;
        reply_fin_reg  <= reply_fin_next;
        div_rem_reg    <= div_rem_next;
        div_dq_reg     <= div_dq_next;
        div_den_reg    <= div_den_next;
        mul_acc_reg    <= mul_acc_next;
        mul_mcand_reg  <= mul_mcand_next;
        mul_mplier_reg <= mul_mplier_next;
        mm_acc_reg     <= mm_acc_next;
        mm_mcand_reg   <= mm_mcand_next;
        sqr_rem_reg    <= sqr_rem_next;
        sqr_root_reg   <= sqr_root_next;
        if (reply_load)
        begin
            grey_out_reg   <= reply_fin_reg ? OUT_W'(0) : map_grey;
            status_out_reg <= fstat_reg;
            fin_out_reg    <= reply_fin_reg;
        end
    end

    assign result_valid      = res_valid_reg;
    assign mapped_grey       = grey_out_reg;
    assign status            = status_out_reg;
    assign is_finalize_reply = fin_out_reg;

endmodule

>>> rtl/msc_checker.sv
`timescale 1ns / 1ps

module msc_checker
    import msc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input logic [OP_W-1:0]     opcode,
    input logic                result_valid,
    input logic                result_stall,
    input logic [OUT_W-1:0]    mapped_grey,
    input logic [STATUS_W-1:0] status,
    input logic                is_finalize_reply,
    input logic                cfg_ready
);

    // A stalled result keeps its payload until the transfer.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(mapped_grey)
                                         && $stable(status) && $stable(is_finalize_reply))
        else $error("stalled result changed");

    // A finalize reply carries no grey level.
    a_fin_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_finalize_reply |-> mapped_grey == '0)
        else $error("finalize reply with nonzero grey level");

    // Only defined status codes are reported.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == STAT_OK || status == STAT_FEW || status == STAT_FLAT))
        else $error("undefined status code");

    // Items that owe a result always leave the block busy in the cycle after they are taken.
    a_reply_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (opcode == OP_FINALIZE || opcode == OP_MAP)
        |=> item_stall)
        else $error("block idle right after a finalize or map item");

    // The configuration port is open exactly while the item channel is.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == !item_stall)
        else $error("configuration port open while busy");

endmodule

bind mean_spread_contrast_stretch msc_checker u_msc_checker (.*);
